/* design/xtea_random_generator_macros.svh */
// assertion macros of the xtea random generator module
`ifndef XTEA_RANDOM_GENERATOR_MACROS_SVH
`define XTEA_RANDOM_GENERATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define XTEA_RNG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define XTEA_RNG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/xtea_rng_pkg.sv */
// types and constants of the xtea random generator
package xtea_rng_pkg;

  localparam logic [31:0] XTEA_DELTA = 32'h9E3779B9;
  localparam logic [31:0] BASE_KEY0  = 32'h2DE9716E;
  localparam logic [31:0] BASE_KEY1  = 32'h993FDDD1;
  localparam logic [31:0] BASE_KEY2  = 32'h2A77FB57;
  localparam logic [31:0] BASE_KEY3  = 32'hB172E6B0;

  localparam int unsigned VALUE_W = 15;

  typedef enum logic [1:0] {
    FUNC_SEED  = 2'd0,
    FUNC_DRAW  = 2'd1,
    FUNC_PEEK2 = 2'd2,
    FUNC_PEEK1 = 2'd3
  } func_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  typedef struct packed {
    logic       start;
    logic       seed;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } ctrl_t;

  typedef struct packed {
    logic        done;
    logic [31:0] xor_final;
    logic [31:0] xor_now;
  } status_t;

endpackage

/* design/xtea_rng_if.sv */
// request and response channel interfaces of the xtea random generator
interface xtea_rng_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [4:0] seed_hour;
  logic [5:0] seed_minute;
  logic [5:0] seed_second;

  modport source (output valid, func, seed_hour, seed_minute, seed_second, input ready);
  modport sink (input valid, func, seed_hour, seed_minute, seed_second, output ready);
endinterface

interface xtea_rng_rsp_if;
  logic        valid;
  logic        ready;
  logic [14:0] value;

  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface

/* design/xtea_rng_half.sv */
// one xtea half round: the shared add/xor/shift unit
module xtea_rng_half (
  input  logic [31:0]      src,
  input  logic [31:0]      dst,
  input  logic [31:0]      acc,
  input  logic [3:0][31:0] key_words,
  input  logic             phase,
  output logic [31:0]      result
);

  logic [1:0]  key_idx;
  logic [31:0] mixed;
  logic [31:0] keyed;

  always_comb begin
    key_idx = phase ? acc[12:11] : acc[1:0];
    mixed   = ((src << 4) ^ (src >> 5)) + src;
    keyed   = acc + key_words[key_idx];
    result  = dst + (mixed ^ keyed);
  end

endmodule

/* design/xtea_rng_core.sv */
// cipher state, key and half-round sequencer of the xtea random generator
module xtea_rng_core #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  xtea_rng_pkg::ctrl_t  ctrl,
  output xtea_rng_pkg::status_t status
);

  localparam int unsigned StepCount = 2 * ROUND_COUNT;
  localparam int unsigned StepW     = $clog2(StepCount);
  localparam logic [StepW-1:0] StepLast = StepW'(StepCount - 1);

  logic [31:0]      word_a;
  logic [31:0]      word_b;
  logic [31:0]      acc;
  logic [3:0][31:0] key_words;
  logic [StepW-1:0] step;
  logic             busy;

  logic [31:0] half_src;
  logic [31:0] half_dst;
  logic [31:0] half_out;

  assign half_src = step[0] ? word_a : word_b;
  assign half_dst = step[0] ? word_b : word_a;

  xtea_rng_half u_half (
    .src       (half_src),
    .dst       (half_dst),
    .acc       (acc),
    .key_words (key_words),
    .phase     (step[0]),
    .result    (half_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      word_a    <= '0;
      word_b    <= '0;
      acc       <= '0;
      key_words <= '0;
      step      <= '0;
      busy      <= 1'b0;
    end else if (ctrl.start) begin
      if (ctrl.seed) begin
        key_words[0] <= xtea_rng_pkg::BASE_KEY0 ^ {26'd0, ctrl.second};
        key_words[1] <= xtea_rng_pkg::BASE_KEY1 ^ {26'd0, ctrl.minute};
        key_words[2] <= xtea_rng_pkg::BASE_KEY2 ^ {27'd0, ctrl.hour};
        key_words[3] <= xtea_rng_pkg::BASE_KEY3;
        word_a       <= '0;
        word_b       <= '0;
      end
      acc  <= '0;
      step <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      if (step[0]) begin
        word_b <= half_out;
      end else begin
        word_a <= half_out;
        acc    <= acc + xtea_rng_pkg::XTEA_DELTA;
      end
      if (step == StepLast) begin
        busy <= 1'b0;
      end
      step <= step + 1'b1;
    end
  end

  assign status.done      = busy && (step == StepLast);
  assign status.xor_final = word_a ^ half_out;
  assign status.xor_now   = word_a ^ word_b;

endmodule

/* design/xtea_random_generator.sv */
// Pseudo-random generator: XTEA encipherment of a 64-bit state under a 128-bit
// key seeded from second, minute and hour. Seed and draw run the ROUND_COUNT
// rounds after the request beat, one half round per cycle through a single
// shared add/xor/shift unit, and the response beat is presented on the cycle
// after the last half round; req.ready is low while the rounds run. Peek
// requests answer on the next cycle. A new request is taken as soon as the
// response register is free or being emptied.
`include "xtea_random_generator_macros.svh"

module xtea_random_generator #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  logic          clk,
  input  logic          rst,
  xtea_rng_req_if.sink   req,
  xtea_rng_rsp_if.source rsp
);

  xtea_rng_pkg::state_t  state;
  xtea_rng_pkg::state_t  state_next;
  xtea_rng_pkg::ctrl_t   ctrl;
  xtea_rng_pkg::status_t status;
  xtea_rng_pkg::func_t   req_func;

  logic        out_valid;
  logic [14:0] out_value;
  logic        draw_pending;
  logic        accept;
  logic        peek_take;

  assign req_func = xtea_rng_pkg::func_t'(req.func);

  xtea_rng_core #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xtea_rng_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req.ready   = 1'b0;
    accept      = 1'b0;
    peek_take   = 1'b0;
    ctrl.start  = 1'b0;
    ctrl.seed   = 1'b0;
    ctrl.hour   = req.seed_hour;
    ctrl.minute = req.seed_minute;
    ctrl.second = req.seed_second;
    unique case (state)
      xtea_rng_pkg::ST_IDLE: begin
        req.ready = !out_valid || rsp.ready;
        accept    = req.valid && req.ready;
        unique case (req_func)
          xtea_rng_pkg::FUNC_SEED: begin
            ctrl.start = accept;
            ctrl.seed  = 1'b1;
          end
          xtea_rng_pkg::FUNC_DRAW: begin
            ctrl.start = accept;
          end
          xtea_rng_pkg::FUNC_PEEK2,
          xtea_rng_pkg::FUNC_PEEK1: begin
            peek_take = accept;
          end
          default: begin
            peek_take = 1'b0;
          end
        endcase
        if (ctrl.start) begin
          state_next = xtea_rng_pkg::ST_RUN;
        end
      end
      xtea_rng_pkg::ST_RUN: begin
        if (status.done) begin
          state_next = xtea_rng_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = xtea_rng_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      draw_pending <= (req_func == xtea_rng_pkg::FUNC_DRAW);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (peek_take || status.done) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (peek_take) begin
      if (req_func == xtea_rng_pkg::FUNC_PEEK2) begin
        out_value <= {13'd0, status.xor_now[16:15]};
      end else begin
        out_value <= {14'd0, status.xor_now[17]};
      end
    end else if (status.done) begin
      out_value <= draw_pending ? status.xor_final[14:0] : '0;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.value = out_value;

  `XTEA_RNG_ASSERT_IMP(a_run_stalls_req, state == xtea_rng_pkg::ST_RUN, !req.ready,
    "request taken while rounds run")
  `XTEA_RNG_ASSERT_IMP(a_run_out_empty, state == xtea_rng_pkg::ST_RUN, !rsp.valid,
    "response pending while rounds run")
  `XTEA_RNG_ASSERT_NXT(a_start_runs, ctrl.start, state == xtea_rng_pkg::ST_RUN,
    "seed or draw did not start the rounds")
  `XTEA_RNG_ASSERT_NXT(a_peek_answers, peek_take,
    rsp.valid && (state == xtea_rng_pkg::ST_IDLE), "peek beat not answered next cycle")
  `XTEA_RNG_ASSERT_IMP(a_done_in_run, status.done, state == xtea_rng_pkg::ST_RUN,
    "round sequence finished outside run state")

endmodule
